### hw/rtl/ntce_pkg.sv
// ----------------------------------------------------------------------------
// ntce_pkg
// Shared types and constants for the numeric token classify/encode unit.
// ----------------------------------------------------------------------------
package ntce_pkg;

  localparam int MAX_DIGITS  = 63;
  localparam int COUNT_W     = 6;
  localparam int VALUE_W     = 10;
  localparam int COUNT_LIMIT = (MAX_DIGITS < 63) ? MAX_DIGITS : 63;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_K      = 8'h6B;

  // classification phase
  typedef enum logic [1:0] {
    PH_BODY = 2'd0,
    PH_K    = 2'd1,
    PH_REJ  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    PFX_NONE     = 2'd0,
    PFX_CURRENCY = 2'd1,
    PFX_PHONE    = 2'd2
  } prefix_t;

  // input stage contents handed to the core
  typedef struct packed {
    logic       valid;
    logic [7:0] char_code;
    logic       last_char;
  } stage_t;

endpackage

### hw/rtl/ntce_if.sv
// ----------------------------------------------------------------------------
// ntce_if
// Valid/ready channels for characters in and token results out.
// ----------------------------------------------------------------------------
interface ntce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface ntce_out_if;
  logic       valid;
  logic       ready;
  logic       is_numeric;
  logic [1:0] prefix_kind;
  logic [5:0] digit_count;
  logic [9:0] digit_value;

  modport source (output valid, output is_numeric, output prefix_kind,
                  output digit_count, output digit_value, input ready);
  modport sink   (input valid, input is_numeric, input prefix_kind,
                  input digit_count, input digit_value, output ready);
endinterface

### hw/rtl/ntce_in_stage.sv
// ----------------------------------------------------------------------------
// ntce_in_stage
// Input register: captures one character request per cycle while it is empty or its held request is taken.
// ----------------------------------------------------------------------------
module ntce_in_stage
  import ntce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ntce_in_if.sink     in_ch,
  input  logic        take,
  output stage_t      stg
);

  logic       valid_r, valid_nxt;
  logic [7:0] char_r;
  logic       last_r;
  logic       accept;

  // empty, or the held request leaves this cycle
  assign in_ch.ready = !valid_r || take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      char_r <= in_ch.char_code;
      last_r <= in_ch.last_char;
    end
  end

  assign stg.valid     = valid_r;
  assign stg.char_code = char_r;
  assign stg.last_char = last_r;

endmodule

### hw/rtl/ntce_core.sv
// ----------------------------------------------------------------------------
// ntce_core
// Per-token parse/classify state, result logic and result register.
// ----------------------------------------------------------------------------
module ntce_core
  import ntce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  stage_t      stg,
  output logic        take,
  ntce_out_if.source  out_ch
);

  localparam logic [COUNT_W:0] LIMIT = (COUNT_W+1)'(COUNT_LIMIT);

  logic                at_start_r;
  phase_t              phase_r, phase_nxt;
  logic                stopped_r, stopped_nxt;
  prefix_t             prefix_r, prefix_nxt;
  logic [COUNT_W-1:0]  digits_r, digits_nxt;
  logic [VALUE_W-1:0]  low_r, low_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                numeric_r, numeric_nxt;
  logic [1:0]          kind_r, kind_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [VALUE_W-1:0]  value_r, value_nxt;

  logic [7:0]          ch;
  logic                is_dig;
  logic                body_ok;
  logic                do_parse;
  logic [COUNT_W:0]    add_n;
  logic [COUNT_W:0]    sum;
  logic [VALUE_W-1:0]  dig_val;

  assign ch      = stg.char_code;
  assign is_dig  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign body_ok = is_dig || (ch == CH_MINUS) || (ch == CH_COMMA) || (ch == CH_DOT);
  assign dig_val = VALUE_W'(ch - CH_ZERO);

  // a result request only moves when the result register is free
  assign take = stg.valid && (!stg.last_char || !out_valid_r || out_ch.ready);

  // first character: '$' or digit, anything else rejects
  assign do_parse = !at_start_r || is_dig;

  always_comb begin
    add_n = '0;
    if (is_dig) begin
      add_n = (COUNT_W+1)'(1);
    end else if (ch == CH_K) begin
      add_n = (COUNT_W+1)'(3);
    end
    sum = {1'b0, digits_r} + add_n;
  end

  always_comb begin
    phase_nxt   = phase_r;
    stopped_nxt = stopped_r;
    prefix_nxt  = prefix_r;
    digits_nxt  = digits_r;
    low_nxt     = low_r;

    if (at_start_r) begin
      if (ch == CH_DOLLAR) begin
        prefix_nxt = PFX_CURRENCY;
      end else if (!is_dig) begin
        phase_nxt = PH_REJ;
      end
    end else if (phase_r == PH_BODY) begin
      if (!body_ok) begin
        phase_nxt = (ch == CH_K) ? PH_K : PH_REJ;
      end
    end else begin
      phase_nxt = PH_REJ;
    end

    if (do_parse && !stopped_r) begin
      if (is_dig) begin
        if (digits_r < COUNT_W'(3)) begin
          low_nxt = (low_r << 3) + (low_r << 1) + dig_val;
        end
        digits_nxt = (sum > LIMIT) ? LIMIT[COUNT_W-1:0] : sum[COUNT_W-1:0];
      end else if (ch == CH_MINUS) begin
        prefix_nxt  = PFX_PHONE;
        stopped_nxt = 1'b1;
      end else if (ch == CH_DOT) begin
        stopped_nxt = 1'b1;
      end else if (ch == CH_K) begin
        digits_nxt  = (sum > LIMIT) ? LIMIT[COUNT_W-1:0] : sum[COUNT_W-1:0];
        stopped_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    numeric_nxt = (phase_nxt != PH_REJ);
    kind_nxt    = '0;
    count_nxt   = '0;
    value_nxt   = '0;
    if (numeric_nxt) begin
      kind_nxt = prefix_nxt;
      if (prefix_nxt == PFX_PHONE) begin
        if (digits_nxt == COUNT_W'(3)) begin
          count_nxt = COUNT_W'(3);
          value_nxt = low_nxt;
        end
      end else begin
        count_nxt = digits_nxt;
        if (digits_nxt == COUNT_W'(1)) begin
          value_nxt = low_nxt;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take && stg.last_char) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r  <= 1'b1;
      phase_r     <= PH_BODY;
      stopped_r   <= 1'b0;
      prefix_r    <= PFX_NONE;
      digits_r    <= '0;
      low_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        if (stg.last_char) begin
          at_start_r <= 1'b1;
          phase_r    <= PH_BODY;
          stopped_r  <= 1'b0;
          prefix_r   <= PFX_NONE;
          digits_r   <= '0;
          low_r      <= '0;
        end else begin
          at_start_r <= 1'b0;
          phase_r    <= phase_nxt;
          stopped_r  <= stopped_nxt;
          prefix_r   <= prefix_nxt;
          digits_r   <= digits_nxt;
          low_r      <= low_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && stg.last_char) begin
      numeric_r <= numeric_nxt;
      kind_r    <= kind_nxt;
      count_r   <= count_nxt;
      value_r   <= value_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.is_numeric  = numeric_r;
  assign out_ch.prefix_kind = kind_r;
  assign out_ch.digit_count = count_r;
  assign out_ch.digit_value = value_r;

endmodule

### hw/rtl/numeric_token_classify_encode_unit.sv
// ----------------------------------------------------------------------------
// numeric_token_classify_encode_unit
// Classifies a character-stream token as numeric and encodes its digit count.
// ----------------------------------------------------------------------------
// Characters of a token arrive one request per cycle on in_ch, the final one
// flagged by last_char; one result per token leaves on out_ch. Throughput is
// one character per cycle while no last character stalls. A character is
// held in the input register, and its token's result is then written into
// the result register. The result register frees the input side while a
// result waits; a new token's last character stalls only if the previous
// result has not been taken.
module numeric_token_classify_encode_unit
  import ntce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ntce_in_if.sink     in_ch,
  ntce_out_if.source  out_ch
);

  stage_t stg;
  logic   take;

  ntce_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .stg   (stg)
  );

  ntce_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .stg    (stg),
    .take   (take),
    .out_ch (out_ch)
  );

`ifndef SYNTH
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.is_numeric |->
      out_ch.prefix_kind == 2'd0 && out_ch.digit_count == '0 && out_ch.digit_value == '0)
    else $error("rejected token carries nonzero fields");

  a_value_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.digit_value != '0 |->
      out_ch.digit_count == 6'd1 ||
      (out_ch.digit_count == 6'd3 && out_ch.prefix_kind == PFX_PHONE))
    else $error("digit value without lone digit or area code");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> 32'(out_ch.digit_count) <= COUNT_LIMIT)
    else $error("digit count beyond limit");

  a_lone_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.digit_count == 6'd1 && out_ch.prefix_kind != PFX_PHONE |->
      out_ch.digit_value <= 10'd9)
    else $error("lone digit value out of range");
`endif

endmodule

### tb/sv/numeric_token_classify_encode_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// numeric_token_classify_encode_unit_test
// Self-checking bench: character tokens in, one classified/encoded result out.
// ----------------------------------------------------------------------------
// Tokens are driven one character per request with random gaps on both sides.
// A local token predictor tracks the classification phase, prefix and digit
// count of each accepted character and queues the verdict expected when the
// last character is taken. Every result taken from the block is compared
// against the oldest queued verdict.
module numeric_token_classify_encode_unit_test;
  import ntce_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic               numeric;
    prefix_t            kind;
    logic [COUNT_W-1:0] count;
    logic [VALUE_W-1:0] value;
  } token_verdict_t;

  logic clk;
  logic rst_n;

  ntce_in_if  in_ch ();
  ntce_out_if out_ch ();

  numeric_token_classify_encode_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  token_verdict_t token_verdicts[$];
  int unsigned    err_count;
  int unsigned    cycle_count;
  int unsigned    sent_chars;
  bit             tx_no_gaps;
  bit             rx_no_gaps;
  logic           hold_off;

  // predictor state for the token in flight
  bit          tok_at_start;
  phase_t      tok_phase;
  bit          tok_stopped;
  prefix_t     tok_prefix;
  int unsigned tok_digits;
  int unsigned tok_low;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ------------------------------------------------------------------------
  // token predictor
  // ------------------------------------------------------------------------
  function automatic bit is_digit(input logic [7:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

  function automatic void clear_token();
    tok_at_start = 1'b1;
    tok_phase    = PH_BODY;
    tok_stopped  = 1'b0;
    tok_prefix   = PFX_NONE;
    tok_digits   = 0;
    tok_low      = 0;
  endfunction

  function automatic void add_digits(input int unsigned n);
    tok_digits = (tok_digits + n > COUNT_LIMIT) ? COUNT_LIMIT : tok_digits + n;
  endfunction

  function automatic void parse_step(input logic [7:0] ch);
    if (tok_stopped) return;
    if (is_digit(ch)) begin
      if (tok_digits < 3) tok_low = tok_low * 10 + int'(ch - CH_ZERO);
      add_digits(1);
    end else if (ch == CH_MINUS) begin
      tok_prefix  = PFX_PHONE;
      tok_stopped = 1'b1;
    end else if (ch == CH_DOT) begin
      tok_stopped = 1'b1;
    end else if (ch == CH_K) begin
      add_digits(3);
      tok_stopped = 1'b1;
    end
  endfunction

  function automatic void classify_step(input logic [7:0] ch);
    if (tok_phase == PH_BODY) begin
      if (is_digit(ch) || ch == CH_MINUS || ch == CH_COMMA || ch == CH_DOT) return;
      tok_phase = (ch == CH_K) ? PH_K : PH_REJ;
    end else begin
      tok_phase = PH_REJ;
    end
  endfunction

  function automatic void predict_char(input logic [7:0] ch, input logic last);
    token_verdict_t v;
    if (tok_at_start) begin
      tok_at_start = 1'b0;
      if (ch == CH_DOLLAR) begin
        tok_prefix = PFX_CURRENCY;
      end else if (is_digit(ch)) begin
        classify_step(ch);
        parse_step(ch);
      end else begin
        tok_phase = PH_REJ;
      end
    end else begin
      classify_step(ch);
      parse_step(ch);
    end
    if (!last) return;
    v = '0;
    v.kind = PFX_NONE;
    if (tok_phase != PH_REJ) begin
      v.numeric = 1'b1;
      v.kind    = tok_prefix;
      if (tok_prefix == PFX_PHONE) begin
        // area code only survives with exactly three digits ahead of the dash
        if (tok_digits == 3) begin
          v.count = COUNT_W'(3);
          v.value = tok_low[VALUE_W-1:0];
        end
      end else begin
        v.count = tok_digits[COUNT_W-1:0];
        if (tok_digits == 1) v.value = tok_low[VALUE_W-1:0];
      end
    end
    token_verdicts = {token_verdicts, v};
    clear_token();
  endfunction

  // ------------------------------------------------------------------------
  // error reporting and result checking
  // ------------------------------------------------------------------------
  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    token_verdict_t exp_v;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (token_verdicts.size() == 0) begin
        note_error($sformatf("unexpected result num=%0b kind=%0d cnt=%0d val=%0d",
                             out_ch.is_numeric, out_ch.prefix_kind,
                             out_ch.digit_count, out_ch.digit_value));
      end else begin
        exp_v = token_verdicts.pop_front();
        if (out_ch.is_numeric !== exp_v.numeric || out_ch.prefix_kind !== exp_v.kind ||
            out_ch.digit_count !== exp_v.count || out_ch.digit_value !== exp_v.value) begin
          note_error($sformatf(
            "exp num=%0b kind=%0d cnt=%0d val=%0d, got num=%0b kind=%0d cnt=%0d val=%0d",
            exp_v.numeric, exp_v.kind, exp_v.count, exp_v.value,
            out_ch.is_numeric, out_ch.prefix_kind, out_ch.digit_count,
            out_ch.digit_value));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // result receiver
  // ------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 15);
  endfunction

  initial begin
    int unsigned gap;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = rx_no_gaps ? 0 : pick_gap();
      if (gap != 0 || hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // ------------------------------------------------------------------------
  // character sender
  // ------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] ch, input logic last);
    int unsigned gap;
    gap = tx_no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= ch;
    in_ch.last_char <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_char(ch, last);
    sent_chars++;
  endtask

  task automatic send_token(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  task automatic send_random_token();
    logic [7:0]  q[$];
    int unsigned shape;
    int unsigned n;
    int unsigned r;
    shape = $urandom_range(0, 9);
    if (shape <= 4 || shape == 8) begin
      if ($urandom_range(0, 2) == 0) q = {q, CH_DOLLAR};
      if (q.size() == 0 || $urandom_range(0, 3) != 0) q = {q, rand_digit()};
      // the odd long run can push the count into saturation
      n = ($urandom_range(0, 30) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 6);
      repeat (n) begin
        r = $urandom_range(0, 9);
        case (r)
          6: q = {q, CH_COMMA};
          7: q = {q, CH_DOT};
          8: q = {q, CH_MINUS};
          default: q = {q, rand_digit()};
        endcase
      end
      if ($urandom_range(0, 3) == 0) q = {q, CH_K};
      if (shape == 8) begin
        r = $urandom_range(0, q.size() - 1);
        case ($urandom_range(0, 2))
          0: q[r] = CH_K;
          1: q[r] = CH_DOLLAR;
          default: q[r] = 8'($urandom_range(0, 255));
        endcase
      end
    end else if (shape <= 6) begin
      if ($urandom_range(0, 4) == 0) q = {q, CH_DOLLAR};
      repeat ($urandom_range(2, 4)) q = {q, rand_digit()};
      q = {q, CH_MINUS};
      repeat ($urandom_range(0, 4)) q = {q, rand_digit()};
    end else if (shape == 7) begin
      repeat ($urandom_range(1, 4)) q = {q, 8'($urandom_range(0, 255))};
    end else begin
      case ($urandom_range(0, 6))
        0: q = {q, CH_DOLLAR};
        1: q = {q, CH_K};
        2: q = {q, CH_MINUS};
        3: q = {q, CH_COMMA};
        4: q = {q, CH_DOT};
        5: q = {q, rand_digit()};
        default: q = {q, 8'($urandom_range(0, 255))};
      endcase
    end
    foreach (q[i]) send_char(q[i], i == q.size() - 1);
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------
  task automatic test_directed_tokens();
    string toks[11] = '{"$", "7", "5k", "1.5", "1,0", "999-", "12-", "1k2", "a", "-", "$9"};
    foreach (toks[i]) send_token(toks[i]);
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_count_saturation();
    send_char(CH_DOLLAR, 1'b0);
    repeat (66) send_char(rand_digit(), 1'b0);
    send_char(CH_K, 1'b1);
  endtask

  task automatic test_random_tokens(input int unsigned n_chars);
    int unsigned start;
    start = sent_chars;
    while (sent_chars - start < n_chars) send_random_token();
  endtask

  task automatic test_back_to_back();
    tx_no_gaps = 1'b1;
    rx_no_gaps = 1'b1;
    test_random_tokens(200);
    tx_no_gaps = 1'b0;
    rx_no_gaps = 1'b0;
  endtask

  // receiver stalls for a long stretch while the sender keeps offering
  task automatic test_result_backpressure();
    tx_no_gaps = 1'b1;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    repeat (40) begin
      if ($urandom_range(0, 1) == 0) send_char(rand_digit(), 1'b1);
      else send_random_token();
    end
    tx_no_gaps = 1'b0;
  endtask

  initial begin
    rst_n           <= 1'b0;
    hold_off        <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.char_code <= '0;
    in_ch.last_char <= 1'b0;
    clear_token();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_tokens();
    test_count_saturation();
    test_random_tokens(550);
    test_back_to_back();
    test_result_backpressure();
    test_random_tokens(200);

    in_ch.valid <= 1'b0;
    while (token_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (token_verdicts.size() != 0 || err_count != 0) begin
      $display("DONE: errors detected");
    end else begin
      $display("DONE: 0 errors");
    end
    $finish;
  end

endmodule

### numeric_token_classify_encode_unit.f
hw/rtl/ntce_pkg.sv
hw/rtl/ntce_if.sv
hw/rtl/ntce_in_stage.sv
hw/rtl/ntce_core.sv
hw/rtl/numeric_token_classify_encode_unit.sv
tb/sv/numeric_token_classify_encode_unit_test.sv
